// File: rtl/core/fpsf_pkg.sv
package fpsf_pkg;

  localparam int ACT_W   = 3;
  localparam int TIME_W  = 16;
  localparam int MODE_W  = 3;
  localparam int COLOR_W = 16;
  localparam int RANGE_W = 17;
  localparam int RATE_W  = 24;

  // full scale of a channel is 2^width LSBs, rates are Q8.16 full scales per second
  localparam int COLOR_SHIFT = 16;
  localparam int RANGE_SHIFT = 15;

  localparam logic [ACT_W-1:0] ACT_TICK    = 3'd0;
  localparam logic [ACT_W-1:0] ACT_SET     = 3'd1;
  localparam logic [ACT_W-1:0] ACT_FADE    = 3'd2;
  localparam logic [ACT_W-1:0] ACT_ROLL    = 3'd3;
  localparam logic [ACT_W-1:0] ACT_DISABLE = 3'd4;

  localparam logic [MODE_W-1:0]  MODE_NONE = '0;
  localparam logic [COLOR_W-1:0] MID_GRAY  = 16'd32768;
  localparam logic [RANGE_W-1:0] NEAR_RESET = '0;
  localparam logic [RANGE_W-1:0] FAR_RESET = 17'd16384;
  localparam logic [RANGE_W-1:0] ROLL_GOAL = 17'd65536;
  localparam logic [RATE_W-1:0]  RATE_MAX  = '1;

  typedef struct packed {
    logic [ACT_W-1:0]   action;
    logic [TIME_W-1:0]  elapsed;
    logic [MODE_W-1:0]  mode;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [RANGE_W-1:0] near;
    logic [RANGE_W-1:0] far;
    logic [RATE_W-1:0]  color_rate;
    logic [RATE_W-1:0]  near_rate;
    logic [RATE_W-1:0]  far_rate;
  } item_t;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [RANGE_W-1:0] near;
    logic [RANGE_W-1:0] far;
  } result_t;

endpackage

// File: rtl/core/fpsf_slew_lane.sv
module fpsf_slew_lane #(
  parameter int W     = fpsf_pkg::COLOR_W,
  parameter int SHIFT = fpsf_pkg::COLOR_SHIFT
) (
  input  logic [W-1:0]                    now,
  input  logic [W-1:0]                    goal,
  input  logic [fpsf_pkg::RATE_W-1:0]     rate,
  input  logic [fpsf_pkg::TIME_W-1:0]     elapsed,
  output logic [W-1:0]                    now_next,
  output logic                            arrived
);

  localparam int PW = fpsf_pkg::RATE_W + fpsf_pkg::TIME_W;
  localparam int SW = PW - SHIFT;

  logic [PW-1:0] prod;
  logic [SW-1:0] step;
  logic          up;
  logic [W-1:0]  span;

  assign prod = PW'(rate) * PW'(elapsed);
  assign step = prod[PW-1:SHIFT];
  assign up   = goal >= now;
  assign span = up ? (goal - now) : (now - goal);

  always_comb begin
    if (step < SW'(span)) begin
      arrived  = 1'b0;
      now_next = up ? (now + step[W-1:0]) : (now - step[W-1:0]);
    end else begin
      arrived  = 1'b1;
      now_next = goal;
    end
  end

endmodule

// File: rtl/core/fpsf_core.sv
module fpsf_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  fpsf_pkg::item_t   item,
  output fpsf_pkg::result_t result
);

  localparam int CW = fpsf_pkg::COLOR_W;
  localparam int RW = fpsf_pkg::RANGE_W;
  localparam int TW = fpsf_pkg::RATE_W;
  localparam int MW = fpsf_pkg::MODE_W;

  logic [CW-1:0] color_now [3];
  logic [CW-1:0] color_goal [3];
  logic [RW-1:0] near_now, far_now, near_goal, far_goal;
  logic [TW-1:0] color_rate, near_rate, far_rate;
  logic [MW-1:0] fog_mode;

  logic [CW-1:0] color_now_next [3];
  logic [CW-1:0] color_goal_next [3];
  logic [RW-1:0] near_now_next, far_now_next, near_goal_next, far_goal_next;
  logic [TW-1:0] color_rate_next, near_rate_next, far_rate_next;
  logic [MW-1:0] fog_mode_next;

  logic [CW-1:0] color_slew [3];
  logic [RW-1:0] near_slew, far_slew;
  logic [4:0]    arr;
  logic          all_arr;
  logic          tick_go;
  logic [CW-1:0] col_in [3];
  logic [TW-1:0] rate_dbl;

  assign col_in[0] = item.red;
  assign col_in[1] = item.green;
  assign col_in[2] = item.blue;

  for (genvar i = 0; i < 3; i++) begin : g_color
    fpsf_slew_lane #(.W(CW), .SHIFT(fpsf_pkg::COLOR_SHIFT)) u_lane (
      .now      (color_now[i]),
      .goal     (color_goal[i]),
      .rate     (color_rate),
      .elapsed  (item.elapsed),
      .now_next (color_slew[i]),
      .arrived  (arr[i])
    );
  end

  fpsf_slew_lane #(.W(RW), .SHIFT(fpsf_pkg::RANGE_SHIFT)) u_near (
    .now      (near_now),
    .goal     (near_goal),
    .rate     (near_rate),
    .elapsed  (item.elapsed),
    .now_next (near_slew),
    .arrived  (arr[3])
  );

  fpsf_slew_lane #(.W(RW), .SHIFT(fpsf_pkg::RANGE_SHIFT)) u_far (
    .now      (far_now),
    .goal     (far_goal),
    .rate     (far_rate),
    .elapsed  (item.elapsed),
    .now_next (far_slew),
    .arrived  (arr[4])
  );

  assign all_arr  = &arr;
  assign tick_go  = (item.action == fpsf_pkg::ACT_TICK) && (fog_mode != fpsf_pkg::MODE_NONE) &&
                    ((color_rate != '0) || (near_rate != '0) || (far_rate != '0));
  assign rate_dbl = item.near_rate[TW-1] ? fpsf_pkg::RATE_MAX : {item.near_rate[TW-2:0], 1'b0};

  always_comb begin
    color_now_next  = color_now;
    color_goal_next = color_goal;
    near_now_next   = near_now;
    far_now_next    = far_now;
    near_goal_next  = near_goal;
    far_goal_next   = far_goal;
    color_rate_next = color_rate;
    near_rate_next  = near_rate;
    far_rate_next   = far_rate;
    fog_mode_next   = fog_mode;
    unique case (item.action)
      fpsf_pkg::ACT_TICK: begin
        if (tick_go) begin
          color_now_next = color_slew;
          far_now_next   = far_slew;
          near_now_next  = (near_slew > far_slew) ? far_slew : near_slew;
          if (all_arr) begin
            color_rate_next = '0;
            near_rate_next  = '0;
            far_rate_next   = '0;
            if (near_slew == far_slew) fog_mode_next = fpsf_pkg::MODE_NONE;
          end
        end
      end
      fpsf_pkg::ACT_SET: begin
        fog_mode_next   = item.mode;
        color_now_next  = col_in;
        color_goal_next = col_in;
        near_now_next   = item.near;
        near_goal_next  = item.near;
        far_now_next    = item.far;
        far_goal_next   = item.far;
      end
      fpsf_pkg::ACT_FADE: begin
        if (fog_mode == fpsf_pkg::MODE_NONE) begin
          color_now_next = col_in;
          near_now_next  = item.far;
          far_now_next   = item.far;
        end
        fog_mode_next   = item.mode;
        color_goal_next = col_in;
        near_goal_next  = item.near;
        far_goal_next   = item.far;
        color_rate_next = item.color_rate;
        near_rate_next  = item.near_rate;
        far_rate_next   = item.far_rate;
      end
      fpsf_pkg::ACT_ROLL: begin
        near_rate_next  = item.near_rate;
        far_rate_next   = rate_dbl;
        near_goal_next  = fpsf_pkg::ROLL_GOAL;
        far_goal_next   = fpsf_pkg::ROLL_GOAL;
        color_rate_next = item.color_rate;
        color_goal_next = col_in;
      end
      fpsf_pkg::ACT_DISABLE: begin
        fog_mode_next = fpsf_pkg::MODE_NONE;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        color_now[i]  <= fpsf_pkg::MID_GRAY;
        color_goal[i] <= fpsf_pkg::MID_GRAY;
      end
      near_now   <= fpsf_pkg::NEAR_RESET;
      far_now    <= fpsf_pkg::FAR_RESET;
      near_goal  <= fpsf_pkg::NEAR_RESET;
      far_goal   <= fpsf_pkg::FAR_RESET;
      color_rate <= '0;
      near_rate  <= '0;
      far_rate   <= '0;
      fog_mode   <= fpsf_pkg::MODE_NONE;
    end else if (en) begin
      color_now  <= color_now_next;
      color_goal <= color_goal_next;
      near_now   <= near_now_next;
      far_now    <= far_now_next;
      near_goal  <= near_goal_next;
      far_goal   <= far_goal_next;
      color_rate <= color_rate_next;
      near_rate  <= near_rate_next;
      far_rate   <= far_rate_next;
      fog_mode   <= fog_mode_next;
    end
  end

  assign result.mode  = fog_mode_next;
  assign result.red   = color_now_next[0];
  assign result.green = color_now_next[1];
  assign result.blue  = color_now_next[2];
  assign result.near  = (near_now_next > far_now_next) ? far_now_next : near_now_next;
  assign result.far   = far_now_next;

  a_rates_clear: assert property (@(posedge clk) disable iff (rst)
    en && tick_go && all_arr |=> color_rate == '0 && near_rate == '0 && far_rate == '0)
    else $error("rates not cleared after arrival");

  a_tick_clamp: assert property (@(posedge clk) disable iff (rst)
    en && tick_go |=> near_now <= far_now)
    else $error("near above far after tick");

  a_roll_mode: assert property (@(posedge clk) disable iff (rst)
    en && item.action == fpsf_pkg::ACT_ROLL |=> fog_mode == $past(fog_mode))
    else $error("roll out changed fog mode");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(fog_mode) && $stable(far_now) && $stable(near_rate))
    else $error("state moved without a transaction");

endmodule

// File: rtl/core/fog_parameter_slew_fader_unit.sv
// Fog parameter slew fader.
// Input channel: in_valid/in_ready with one action per transaction (tick,
// set, fade, roll out, disable) and its operand fields. Output channel:
// out_valid/out_ready carrying the fog state after that action; every input
// transaction yields exactly one output transaction, in order.
// Timing: a transaction taken at a clock edge is registered, its state
// update and result are computed combinationally from the input register,
// and the result is loaded into the output register when it can advance.
// Throughput: one transaction per cycle while out_ready is high; the five
// 24x16 step multipliers and their distance compares sit between the input
// register and the state and result registers.
// Stall: while out_ready is low the result register holds, the input
// register holds its transaction, and in_ready drops once both are full.
// Reset (rst, synchronous): colors mid gray, near 0, far 16384, all rates
// zero, fog off; both pipeline registers empty.
module fog_parameter_slew_fader_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [fpsf_pkg::ACT_W-1:0]       action,
  input  logic [fpsf_pkg::TIME_W-1:0]      elapsed,
  input  logic [fpsf_pkg::MODE_W-1:0]      mode_in,
  input  logic [fpsf_pkg::COLOR_W-1:0]     red_in,
  input  logic [fpsf_pkg::COLOR_W-1:0]     green_in,
  input  logic [fpsf_pkg::COLOR_W-1:0]     blue_in,
  input  logic [fpsf_pkg::RANGE_W-1:0]     near_in,
  input  logic [fpsf_pkg::RANGE_W-1:0]     far_in,
  input  logic [fpsf_pkg::RATE_W-1:0]      color_rate_in,
  input  logic [fpsf_pkg::RATE_W-1:0]      near_rate_in,
  input  logic [fpsf_pkg::RATE_W-1:0]      far_rate_in,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [fpsf_pkg::MODE_W-1:0]      mode_out,
  output logic [fpsf_pkg::COLOR_W-1:0]     red_out,
  output logic [fpsf_pkg::COLOR_W-1:0]     green_out,
  output logic [fpsf_pkg::COLOR_W-1:0]     blue_out,
  output logic [fpsf_pkg::RANGE_W-1:0]     near_out,
  output logic [fpsf_pkg::RANGE_W-1:0]     far_out
);

  fpsf_pkg::item_t   item;
  fpsf_pkg::result_t res_next;
  fpsf_pkg::result_t res;
  logic              item_valid;
  logic              advance;
  logic              in_take;

  assign advance  = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || advance;
  assign in_take  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_take) item_valid <= 1'b1;
      else if (advance) item_valid <= 1'b0;
      if (advance) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item.action     <= action;
      item.elapsed    <= elapsed;
      item.mode       <= mode_in;
      item.red        <= red_in;
      item.green      <= green_in;
      item.blue       <= blue_in;
      item.near       <= near_in;
      item.far        <= far_in;
      item.color_rate <= color_rate_in;
      item.near_rate  <= near_rate_in;
      item.far_rate   <= far_rate_in;
    end
    if (advance) res <= res_next;
  end

  fpsf_core u_core (
    .clk    (clk),
    .rst    (rst),
    .en     (advance),
    .item   (item),
    .result (res_next)
  );

  assign mode_out  = res.mode;
  assign red_out   = res.red;
  assign green_out = res.green;
  assign blue_out  = res.blue;
  assign near_out  = res.near;
  assign far_out   = res.far;

  a_near_le_far: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> near_out <= far_out)
    else $error("reported near above far");

endmodule

// File: tb/fog_parameter_slew_fader_unit_test.sv
`timescale 1ns / 1ps

module fog_parameter_slew_fader_unit_test;

  localparam int STALL_LIMIT  = 1000;
  localparam int RANDOM_ITEMS = 1950;
  localparam int PLAN_ROWS    = 25;
  localparam int HOLD_LEN     = 120;
  localparam int DRAIN_CYCLES = 8;

  localparam logic [fpsf_pkg::ACT_W-1:0] ACT_RSVD5 = 3'd5;
  localparam logic [fpsf_pkg::ACT_W-1:0] ACT_RSVD6 = 3'd6;
  localparam logic [fpsf_pkg::ACT_W-1:0] ACT_RSVD7 = 3'd7;

  localparam logic [fpsf_pkg::MODE_W-1:0]  MODE_A     = 3'd1;
  localparam logic [fpsf_pkg::MODE_W-1:0]  MODE_B     = 3'd2;
  localparam logic [fpsf_pkg::MODE_W-1:0]  MODE_MAX   = '1;
  localparam logic [fpsf_pkg::COLOR_W-1:0] COLOR_MAX  = '1;
  localparam logic [fpsf_pkg::COLOR_W-1:0] COLOR_ZERO = '0;
  localparam logic [fpsf_pkg::RANGE_W-1:0] RANGE_ZERO = '0;

  localparam fpsf_pkg::result_t RESET_VIEW =
    {fpsf_pkg::MODE_NONE, fpsf_pkg::MID_GRAY, fpsf_pkg::MID_GRAY, fpsf_pkg::MID_GRAY,
     fpsf_pkg::NEAR_RESET, fpsf_pkg::FAR_RESET};

  typedef struct packed {
    fpsf_pkg::item_t   stim;
    logic              typed;
    fpsf_pkg::result_t want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [fpsf_pkg::ACT_W-1:0]   action = '0;
  logic [fpsf_pkg::TIME_W-1:0]  elapsed = '0;
  logic [fpsf_pkg::MODE_W-1:0]  mode_in = '0;
  logic [fpsf_pkg::COLOR_W-1:0] red_in = '0;
  logic [fpsf_pkg::COLOR_W-1:0] green_in = '0;
  logic [fpsf_pkg::COLOR_W-1:0] blue_in = '0;
  logic [fpsf_pkg::RANGE_W-1:0] near_in = '0;
  logic [fpsf_pkg::RANGE_W-1:0] far_in = '0;
  logic [fpsf_pkg::RATE_W-1:0]  color_rate_in = '0;
  logic [fpsf_pkg::RATE_W-1:0]  near_rate_in = '0;
  logic [fpsf_pkg::RATE_W-1:0]  far_rate_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [fpsf_pkg::MODE_W-1:0]  mode_out;
  logic [fpsf_pkg::COLOR_W-1:0] red_out;
  logic [fpsf_pkg::COLOR_W-1:0] green_out;
  logic [fpsf_pkg::COLOR_W-1:0] blue_out;
  logic [fpsf_pkg::RANGE_W-1:0] near_out;
  logic [fpsf_pkg::RANGE_W-1:0] far_out;

  // predicted fog state: colors red/green/blue, distances near/far
  logic [fpsf_pkg::COLOR_W-1:0] hue_now [3];
  logic [fpsf_pkg::COLOR_W-1:0] hue_goal [3];
  logic [fpsf_pkg::RANGE_W-1:0] reach_now [2];
  logic [fpsf_pkg::RANGE_W-1:0] reach_goal [2];
  logic [fpsf_pkg::RATE_W-1:0]  hue_rate;
  logic [fpsf_pkg::RATE_W-1:0]  reach_rate [2];
  logic [fpsf_pkg::MODE_W-1:0]  fog_mode_q;

  fpsf_pkg::result_t fog_views_due [$];
  fpsf_pkg::result_t due;
  plan_row_t         plan [PLAN_ROWS];
  int                errors = 0;
  int                idle_cycles = 0;
  int                burst_left = 0;
  int                real_items = 0;

  always #6 clk = ~clk;

  fog_parameter_slew_fader_unit dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .action(action),
    .elapsed(elapsed),
    .mode_in(mode_in),
    .red_in(red_in),
    .green_in(green_in),
    .blue_in(blue_in),
    .near_in(near_in),
    .far_in(far_in),
    .color_rate_in(color_rate_in),
    .near_rate_in(near_rate_in),
    .far_rate_in(far_rate_in),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .mode_out(mode_out),
    .red_out(red_out),
    .green_out(green_out),
    .blue_out(blue_out),
    .near_out(near_out),
    .far_out(far_out)
  );

  // bit 17: arrived, low bits: new value
  function automatic logic [17:0] slew_toward(logic [16:0] now, logic [16:0] goal,
                                              logic [39:0] step);
    logic [16:0] span;
    span = (goal >= now) ? goal - now : now - goal;
    if (step < {23'd0, span})
      return {1'b0, (goal >= now) ? now + step[16:0] : now - step[16:0]};
    return {1'b1, goal};
  endfunction

  task automatic advance_fog(input fpsf_pkg::item_t it, output fpsf_pkg::result_t view);
    logic [39:0] hue_step;
    logic [39:0] near_step;
    logic [39:0] far_step;
    logic [17:0] moved;
    logic [24:0] doubled;
    logic [fpsf_pkg::COLOR_W-1:0] shade [3];
    int arrived;
    arrived = 0;
    shade[0] = it.red;
    shade[1] = it.green;
    shade[2] = it.blue;
    case (it.action)
      fpsf_pkg::ACT_TICK: begin
        if (fog_mode_q != fpsf_pkg::MODE_NONE &&
            (hue_rate | reach_rate[0] | reach_rate[1]) != '0) begin
          hue_step = (hue_rate * it.elapsed) >> fpsf_pkg::COLOR_SHIFT;
          near_step = (reach_rate[0] * it.elapsed) >> fpsf_pkg::RANGE_SHIFT;
          far_step = (reach_rate[1] * it.elapsed) >> fpsf_pkg::RANGE_SHIFT;
          for (int i = 0; i < 3; i++) begin
            moved = slew_toward({1'b0, hue_now[i]}, {1'b0, hue_goal[i]}, hue_step);
            hue_now[i] = moved[15:0];
            arrived += moved[17] ? 1 : 0;
          end
          moved = slew_toward(reach_now[0], reach_goal[0], near_step);
          reach_now[0] = moved[16:0];
          arrived += moved[17] ? 1 : 0;
          moved = slew_toward(reach_now[1], reach_goal[1], far_step);
          reach_now[1] = moved[16:0];
          arrived += moved[17] ? 1 : 0;
          if (arrived == 5) begin
            hue_rate = '0;
            reach_rate[0] = '0;
            reach_rate[1] = '0;
            if (reach_now[0] == reach_now[1]) fog_mode_q = fpsf_pkg::MODE_NONE;
          end
          if (reach_now[0] > reach_now[1]) reach_now[0] = reach_now[1];
        end
      end
      fpsf_pkg::ACT_SET: begin
        fog_mode_q = it.mode;
        for (int i = 0; i < 3; i++) begin
          hue_now[i] = shade[i];
          hue_goal[i] = shade[i];
        end
        reach_now[0] = it.near;
        reach_goal[0] = it.near;
        reach_now[1] = it.far;
        reach_goal[1] = it.far;
      end
      fpsf_pkg::ACT_FADE: begin
        if (fog_mode_q == fpsf_pkg::MODE_NONE) begin
          for (int i = 0; i < 3; i++) hue_now[i] = shade[i];
          reach_now[0] = it.far;
          reach_now[1] = it.far;
        end
        fog_mode_q = it.mode;
        for (int i = 0; i < 3; i++) hue_goal[i] = shade[i];
        reach_goal[0] = it.near;
        reach_goal[1] = it.far;
        hue_rate = it.color_rate;
        reach_rate[0] = it.near_rate;
        reach_rate[1] = it.far_rate;
      end
      fpsf_pkg::ACT_ROLL: begin
        doubled = {it.near_rate, 1'b0};
        reach_rate[0] = it.near_rate;
        reach_rate[1] = (doubled > fpsf_pkg::RATE_MAX) ? fpsf_pkg::RATE_MAX :
                        doubled[fpsf_pkg::RATE_W-1:0];
        reach_goal[0] = fpsf_pkg::ROLL_GOAL;
        reach_goal[1] = fpsf_pkg::ROLL_GOAL;
        hue_rate = it.color_rate;
        for (int i = 0; i < 3; i++) hue_goal[i] = shade[i];
      end
      fpsf_pkg::ACT_DISABLE: fog_mode_q = fpsf_pkg::MODE_NONE;
      default: ;
    endcase
    view.mode = fog_mode_q;
    view.red = hue_now[0];
    view.green = hue_now[1];
    view.blue = hue_now[2];
    view.near = (reach_now[0] > reach_now[1]) ? reach_now[1] : reach_now[0];
    view.far = reach_now[1];
  endtask

  function automatic fpsf_pkg::item_t pack_item(
    logic [fpsf_pkg::ACT_W-1:0] act, logic [fpsf_pkg::TIME_W-1:0] dt,
    logic [fpsf_pkg::MODE_W-1:0] md,
    logic [fpsf_pkg::COLOR_W-1:0] r, logic [fpsf_pkg::COLOR_W-1:0] g,
    logic [fpsf_pkg::COLOR_W-1:0] b,
    logic [fpsf_pkg::RANGE_W-1:0] nr, logic [fpsf_pkg::RANGE_W-1:0] fr,
    logic [fpsf_pkg::RATE_W-1:0] crate, logic [fpsf_pkg::RATE_W-1:0] nrate,
    logic [fpsf_pkg::RATE_W-1:0] frate);
    return {act, dt, md, r, g, b, nr, fr, crate, nrate, frate};
  endfunction

  function automatic logic [fpsf_pkg::RATE_W-1:0] random_rate();
    int pick;
    logic [31:0] raw;
    pick = $urandom_range(0, 9);
    raw = $urandom;
    if (pick == 0) return '0;
    if (pick == 1) return raw[fpsf_pkg::RATE_W-1:0];
    if (pick == 2) return fpsf_pkg::RATE_MAX;
    raw = $urandom_range(0, 'hFFFF);
    return raw[fpsf_pkg::RATE_W-1:0];
  endfunction

  function automatic logic [fpsf_pkg::COLOR_W-1:0] random_color();
    logic [31:0] raw;
    raw = $urandom;
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? COLOR_MAX : COLOR_ZERO;
    return raw[fpsf_pkg::COLOR_W-1:0];
  endfunction

  function automatic fpsf_pkg::item_t random_item(logic [fpsf_pkg::ACT_W-1:0] act);
    fpsf_pkg::item_t it;
    int pick;
    logic [31:0] raw;
    it.action = act;
    pick = $urandom_range(0, 9);
    if (pick < 6) raw = $urandom_range(0, 'h1FFF);
    else if (pick < 9) raw = $urandom_range(0, 'h200);
    else raw = $urandom;
    it.elapsed = raw[fpsf_pkg::TIME_W-1:0];
    raw = $urandom_range(1, 7);
    it.mode = ($urandom_range(0, 9) == 0) ? fpsf_pkg::MODE_NONE : raw[fpsf_pkg::MODE_W-1:0];
    it.red = random_color();
    it.green = random_color();
    it.blue = random_color();
    raw = $urandom;
    it.near = raw[fpsf_pkg::RANGE_W-1:0];
    raw = $urandom;
    it.far = raw[fpsf_pkg::RANGE_W-1:0];
    if ($urandom_range(0, 3) == 0) it.near = it.far;
    it.color_rate = random_rate();
    it.near_rate = random_rate();
    it.far_rate = random_rate();
    return it;
  endfunction

  task automatic offer_item(input fpsf_pkg::item_t it, input logic typed,
                            input fpsf_pkg::result_t want);
    fpsf_pkg::result_t view;
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    action <= it.action;
    elapsed <= it.elapsed;
    mode_in <= it.mode;
    red_in <= it.red;
    green_in <= it.green;
    blue_in <= it.blue;
    near_in <= it.near;
    far_in <= it.far;
    color_rate_in <= it.color_rate;
    near_rate_in <= it.near_rate;
    far_rate_in <= it.far_rate;
    do @(posedge clk); while (!in_ready);
    advance_fog(it, view);
    fog_views_due.insert(fog_views_due.size(), typed ? want : view);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic compare_field(input string name, input logic [23:0] want,
                               input logic [23:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (fog_views_due.size() == 0) begin
        $display("%0t ns: result transaction with nothing pending", $time);
        errors++;
      end else begin
        due = fog_views_due[0];
        fog_views_due.delete(0);
        compare_field("mode_out", 24'(due.mode), 24'(mode_out));
        compare_field("red_out", 24'(due.red), 24'(red_out));
        compare_field("green_out", 24'(due.green), 24'(green_out));
        compare_field("blue_out", 24'(due.blue), 24'(blue_out));
        compare_field("near_out", 24'(due.near), 24'(near_out));
        compare_field("far_out", 24'(due.far), 24'(far_out));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("** fog_parameter_slew_fader_unit: FAILED **");
      $finish;
    end
  end

  // receiver: changing stall styles, plus long hold-offs to back up the input
  initial begin
    int cyc;
    int style;
    int style_left;
    cyc = 0;
    style = 0;
    style_left = 0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc == 1200 || cyc == 3600) begin
        out_ready <= 1'b0;
        repeat (HOLD_LEN) @(negedge clk);
      end
      if (style_left == 0) begin
        style = $urandom_range(0, 3);
        style_left = $urandom_range(10, 80);
      end
      style_left--;
      case (style)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 1) == 1);
        2: out_ready <= ($urandom_range(0, 4) == 0);
        default: out_ready <= (cyc % 3 != 0);
      endcase
    end
  end

  initial begin
    logic [fpsf_pkg::ACT_W-1:0] lead;
    int pick;
    logic [31:0] raw;
    for (int i = 0; i < 3; i++) begin
      hue_now[i] = fpsf_pkg::MID_GRAY;
      hue_goal[i] = fpsf_pkg::MID_GRAY;
    end
    reach_now[0] = fpsf_pkg::NEAR_RESET;
    reach_goal[0] = fpsf_pkg::NEAR_RESET;
    reach_now[1] = fpsf_pkg::FAR_RESET;
    reach_goal[1] = fpsf_pkg::FAR_RESET;
    hue_rate = '0;
    reach_rate[0] = '0;
    reach_rate[1] = '0;
    fog_mode_q = fpsf_pkg::MODE_NONE;

    plan[0] = {pack_item(fpsf_pkg::ACT_TICK, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1), 1'b1,
               RESET_VIEW};
    plan[1] = {pack_item(ACT_RSVD5, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1), 1'b1, RESET_VIEW};
    plan[2] = {pack_item(ACT_RSVD6, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1), 1'b1, RESET_VIEW};
    plan[3] = {pack_item(ACT_RSVD7, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1), 1'b1, RESET_VIEW};
    plan[4] = {pack_item(fpsf_pkg::ACT_DISABLE, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1), 1'b1,
               RESET_VIEW};
    plan[5] = {pack_item(fpsf_pkg::ACT_SET, '0, MODE_MAX, '1, '1, '1, '1, '0, '1, '1, '1), 1'b1,
               {MODE_MAX, COLOR_MAX, COLOR_MAX, COLOR_MAX, RANGE_ZERO, RANGE_ZERO}};
    plan[6] = {pack_item(fpsf_pkg::ACT_TICK, '1, '0, '0, '0, '0, '0, '0, '0, '0, '0), 1'b1,
               {MODE_MAX, COLOR_MAX, COLOR_MAX, COLOR_MAX, RANGE_ZERO, RANGE_ZERO}};
    plan[7] = {pack_item(fpsf_pkg::ACT_SET, '0, MODE_A, '0, '0, '0, 'h100, 'h2000, '0, '0, '0),
               1'b1, {MODE_A, COLOR_ZERO, COLOR_ZERO, COLOR_ZERO, 17'h100, 17'h2000}};
    plan[8] = {pack_item(fpsf_pkg::ACT_FADE, '0, MODE_B, 'hFFFF, 'h8000, '0, 'h40, 'h6000,
                         'h4000, 'h800, 'h1000), 1'b0, RESET_VIEW};
    plan[9] = {pack_item(fpsf_pkg::ACT_TICK, 'h1000, '0, '0, '0, '0, '0, '0, '0, '0, '0), 1'b0,
               RESET_VIEW};
    plan[10] = {pack_item(fpsf_pkg::ACT_TICK, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0), 1'b0,
                RESET_VIEW};
    plan[11] = {pack_item(fpsf_pkg::ACT_TICK, '1, '0, '0, '0, '0, '0, '0, '0, '0, '0), 1'b0,
                RESET_VIEW};
    plan[12] = {pack_item(fpsf_pkg::ACT_FADE, '0, MODE_MAX, 'h1234, 'hFEDC, 'h0F0F, '1, 'h10,
                          fpsf_pkg::RATE_MAX, fpsf_pkg::RATE_MAX, fpsf_pkg::RATE_MAX), 1'b0,
                RESET_VIEW};
    plan[13] = {pack_item(fpsf_pkg::ACT_TICK, 'h1, '0, '0, '0, '0, '0, '0, '0, '0, '0), 1'b0,
                RESET_VIEW};
    plan[14] = {pack_item(fpsf_pkg::ACT_TICK, '1, '0, '0, '0, '0, '0, '0, '0, '0, '0), 1'b0,
                RESET_VIEW};
    plan[15] = {pack_item(fpsf_pkg::ACT_ROLL, '0, '0, '0, '0, '0, '0, '0, 'h8000,
                          fpsf_pkg::RATE_MAX, '0), 1'b0, RESET_VIEW};
    plan[16] = {pack_item(fpsf_pkg::ACT_TICK, '1, '0, '0, '0, '0, '0, '0, '0, '0, '0), 1'b0,
                RESET_VIEW};
    plan[17] = {pack_item(fpsf_pkg::ACT_FADE, '0, MODE_A, 'hAAAA, 'h5555, 'hFFFF, '0, '1,
                          'h100, 'h100, 'h100), 1'b0, RESET_VIEW};
    plan[18] = {pack_item(fpsf_pkg::ACT_ROLL, '0, '0, 'h7000, 'h7000, 'h7000, '0, '0,
                          'h300, 'h7FFFFF, '0), 1'b0, RESET_VIEW};
    plan[19] = {pack_item(fpsf_pkg::ACT_TICK, 'h8000, '0, '0, '0, '0, '0, '0, '0, '0, '0), 1'b0,
                RESET_VIEW};
    plan[20] = {pack_item(fpsf_pkg::ACT_ROLL, '0, '0, '0, '0, '0, '0, '0, '0, 'h800000, '0),
                1'b0, RESET_VIEW};
    plan[21] = {pack_item(fpsf_pkg::ACT_SET, '0, fpsf_pkg::MODE_NONE, 'h1111, 'h2222, 'h3333,
                          'h5, 'h5, '0, '0, '0), 1'b1,
                {fpsf_pkg::MODE_NONE, 16'h1111, 16'h2222, 16'h3333, 17'h5, 17'h5}};
    plan[22] = {pack_item(fpsf_pkg::ACT_FADE, '0, fpsf_pkg::MODE_NONE, 'h4444, 'h5555, 'h6666,
                          'h20, 'h900, 'h1000, 'h1000, 'h1000), 1'b0, RESET_VIEW};
    plan[23] = {pack_item(fpsf_pkg::ACT_TICK, '1, '0, '0, '0, '0, '0, '0, '0, '0, '0), 1'b0,
                RESET_VIEW};
    plan[24] = {pack_item(fpsf_pkg::ACT_SET, '0, MODE_A, fpsf_pkg::MID_GRAY, fpsf_pkg::MID_GRAY,
                          fpsf_pkg::MID_GRAY, fpsf_pkg::NEAR_RESET, fpsf_pkg::FAR_RESET,
                          '0, '0, '0), 1'b1,
                {MODE_A, fpsf_pkg::MID_GRAY, fpsf_pkg::MID_GRAY, fpsf_pkg::MID_GRAY,
                 fpsf_pkg::NEAR_RESET, fpsf_pkg::FAR_RESET}};

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < PLAN_ROWS; i++) offer_item(plan[i].stim, plan[i].typed, plan[i].want);

    // mostly a fade, set or roll out followed by a run of ticks; some noise between
    while (real_items < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 19);
      if (pick < 10) lead = fpsf_pkg::ACT_FADE;
      else if (pick < 13) lead = fpsf_pkg::ACT_SET;
      else if (pick < 16) lead = fpsf_pkg::ACT_ROLL;
      else if (pick < 18) lead = fpsf_pkg::ACT_DISABLE;
      else if (pick < 19) lead = fpsf_pkg::ACT_TICK;
      else begin
        raw = $urandom_range(ACT_RSVD5, ACT_RSVD7);
        lead = raw[fpsf_pkg::ACT_W-1:0];
      end
      offer_item(random_item(lead), 1'b0, RESET_VIEW);
      if (lead <= fpsf_pkg::ACT_DISABLE) real_items++;
      repeat ($urandom_range(0, 12)) begin
        offer_item(random_item(fpsf_pkg::ACT_TICK), 1'b0, RESET_VIEW);
        real_items++;
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (fog_views_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("** fog_parameter_slew_fader_unit: PASSED **");
    end else begin
      $display("** fog_parameter_slew_fader_unit: FAILED **");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/fpsf_pkg.sv
rtl/core/fpsf_slew_lane.sv
rtl/core/fpsf_core.sv
rtl/core/fog_parameter_slew_fader_unit.sv
tb/fog_parameter_slew_fader_unit_test.sv
